// ===== rtl/dhcpc_pkg.sv =====
package dhcpc_pkg;

    localparam int DhcpcMaxFrameBytes = 2048;

    localparam logic [1:0] MODE_RX    = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;
    localparam logic [1:0] MODE_STOP  = 2'd3;

    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_DISCOVER = 2'd1;
    localparam logic [1:0] ST_REQUEST  = 2'd2;
    localparam logic [1:0] ST_BOUND    = 2'd3;

    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_DISCOVER = 2'd1;
    localparam logic [1:0] ACT_REQUEST  = 2'd2;
    localparam logic [1:0] ACT_ARP      = 2'd3;

    localparam logic [7:0] MSG_OFFER = 8'd2;
    localparam logic [7:0] MSG_ACK   = 8'd5;
    localparam logic [7:0] MSG_NAK   = 8'd6;

    localparam logic [2:0] REG_ENABLE   = 3'd0;
    localparam logic [2:0] REG_XID      = 3'd1;
    localparam logic [2:0] REG_RETX     = 3'd2;
    localparam logic [2:0] REG_MAXTRY   = 3'd3;
    localparam logic [2:0] REG_FALLBACK = 3'd4;

    localparam logic [31:0] DEFAULT_MASK = 32'hFFFF_FF00;

    // Command word handed from the front part to the back part.
    typedef enum logic [1:0] {
        CMD_FRAME = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_START = 2'd2,
        CMD_STOP  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] now_ms;
        logic        frame_ok;
        logic [7:0]  msg_type;
        logic [31:0] yiaddr;
        logic [31:0] server;
        logic [31:0] mask;
        logic [31:0] router;
        logic [31:0] dns;
        logic [31:0] lease;
    } t_job;

endpackage

// ===== rtl/dhcpc_parser.sv =====
module dhcpc_parser
    import dhcpc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DhcpcMaxFrameBytes
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_last_byte,
    input  logic [31:0] i_now_ms,
    input  logic [31:0] i_xid,
    output logic        o_job_valid,
    output t_job        o_job
);
    localparam int IW = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [IW-1:0] MaxIdx = IW'(MAX_FRAME_BYTES);

    localparam logic [1:0] PH_TAG = 2'd0;
    localparam logic [1:0] PH_LEN = 2'd1;
    localparam logic [1:0] PH_VAL = 2'd2;

    logic [IW-1:0] r_idx;
    logic [5:0]    r_hlen;
    logic          r_reject, r_ended;
    logic [1:0]    r_phase;
    logic [7:0]    r_tag, r_rem, r_pos;
    logic [31:0]   r_val;
    logic [7:0]    r_msg;
    logic [31:0]   r_yi, r_srv, r_mask, r_rtr, r_dns, r_lease;

    logic [IW-1:0] n_idx;
    logic [5:0]    n_hlen;
    logic          n_reject, n_ended;
    logic [1:0]    n_phase;
    logic [7:0]    n_tag, n_rem, n_pos;
    logic [31:0]   n_val;
    logic [7:0]    n_msg;
    logic [31:0]   n_yi, n_srv, n_mask, n_rtr, n_dns, n_lease;

    logic [12:0]   doff, idx13, rel;
    logic          take, first;
    logic [IW-1:0] len;
    logic [31:0]   shv;
    logic [7:0]    b, xb;

    always_comb begin
        b = i_rx_byte;
        take  = i_valid && (i_mode == MODE_RX) && (r_idx < MaxIdx);
        first = (r_idx == '0);
        n_idx = r_idx; n_hlen = r_hlen; n_reject = r_reject; n_ended = r_ended;
        n_phase = r_phase; n_tag = r_tag; n_rem = r_rem; n_pos = r_pos; n_val = r_val;
        n_msg = r_msg; n_yi = r_yi; n_srv = r_srv; n_mask = r_mask;
        n_rtr = r_rtr; n_dns = r_dns; n_lease = r_lease;
        if (first) begin
            n_hlen = '0; n_reject = 1'b0; n_ended = 1'b0; n_phase = PH_TAG;
            n_tag = '0; n_rem = '0; n_pos = '0; n_val = '0; n_msg = '0;
            n_yi = '0; n_srv = '0; n_mask = DEFAULT_MASK; n_rtr = '0;
            n_dns = '0; n_lease = '0;
        end
        idx13 = 13'(r_idx);
        doff  = 13'd22 + 13'(n_hlen);
        rel   = idx13 - doff;
        case (rel[1:0])
            2'd0:    xb = i_xid[31:24];
            2'd1:    xb = i_xid[23:16];
            2'd2:    xb = i_xid[15:8];
            default: xb = i_xid[7:0];
        endcase
        shv = {r_val[23:0], b};
        if (take) begin
            if (idx13 == 13'd14) n_hlen = {b[3:0], 2'b00};
            if (idx13 == 13'd23 && b != 8'h11) n_reject = 1'b1;
            if (idx13 >= 13'd16) begin
                if (idx13 == doff - 13'd6 && b != 8'h00) n_reject = 1'b1;
                if (idx13 == doff - 13'd5 && b != 8'd68) n_reject = 1'b1;
                if (idx13 == doff && b != 8'h02) n_reject = 1'b1;
                if (idx13 >= doff + 13'd4 && idx13 <= doff + 13'd7 && b != xb)
                    n_reject = 1'b1;
                if (idx13 >= doff + 13'd16 && idx13 <= doff + 13'd19)
                    n_yi = {n_yi[23:0], b};
                if (idx13 == doff + 13'd236 && b != 8'h63) n_reject = 1'b1;
                if (idx13 == doff + 13'd237 && b != 8'h82) n_reject = 1'b1;
                if (idx13 == doff + 13'd238 && b != 8'h53) n_reject = 1'b1;
                if (idx13 == doff + 13'd239 && b != 8'h63) n_reject = 1'b1;
                if (idx13 >= doff + 13'd240 && !n_ended) begin
                    case (n_phase)
                        PH_TAG: begin
                            if (b == 8'hFF) n_ended = 1'b1;
                            else if (b != 8'h00) begin
                                n_tag = b; n_phase = PH_LEN;
                            end
                        end
                        PH_LEN: begin
                            n_rem = b; n_pos = '0; n_val = '0;
                            n_phase = (b == 8'h00) ? PH_TAG : PH_VAL;
                        end
                        default: begin
                            shv   = {n_val[23:0], b};
                            n_val = shv;
                            n_pos = n_pos + 8'd1;
                            if (n_tag == 8'd53 && n_pos == 8'd1) n_msg = b;
                            if (n_pos == 8'd4) begin
                                case (n_tag)
                                    8'd1:    n_mask  = shv;
                                    8'd3:    n_rtr   = shv;
                                    8'd6:    n_dns   = shv;
                                    8'd51:   n_lease = shv;
                                    8'd54:   n_srv   = shv;
                                    default: ;
                                endcase
                            end
                            n_rem = n_rem - 8'd1;
                            if (n_rem == 8'd0) n_phase = PH_TAG;
                        end
                    endcase
                end
            end
            n_idx = r_idx + IW'(1);
        end
        len = n_idx;
        if (i_valid && i_mode == MODE_RX && i_last_byte) n_idx = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0; r_hlen <= '0; r_reject <= 1'b0; r_ended <= 1'b0;
            r_phase <= PH_TAG; r_tag <= '0; r_rem <= '0; r_pos <= '0; r_val <= '0;
            r_msg <= '0; r_yi <= '0; r_srv <= '0; r_mask <= DEFAULT_MASK;
            r_rtr <= '0; r_dns <= '0; r_lease <= '0;
            o_job_valid <= 1'b0;
        end else begin
            if (i_valid && i_mode == MODE_RX) begin
                r_idx <= n_idx; r_hlen <= n_hlen; r_reject <= n_reject;
                r_ended <= n_ended; r_phase <= n_phase; r_tag <= n_tag;
                r_rem <= n_rem; r_pos <= n_pos; r_val <= n_val; r_msg <= n_msg;
                r_yi <= n_yi; r_srv <= n_srv; r_mask <= n_mask; r_rtr <= n_rtr;
                r_dns <= n_dns; r_lease <= n_lease;
            end
            o_job_valid <= i_valid;
        end
    end

    // Per-frame captures travel with the job; only the frame end uses them.
    // A mid-frame byte goes out as a frame word that is never acceptable.
    always_ff @(posedge i_clk) begin
        o_job.cmd      <= t_cmd'(i_mode);
        o_job.now_ms   <= i_now_ms;
        o_job.frame_ok <= i_last_byte && !n_reject && (32'(len) >= 32'd300)
                          && (32'(len) >= 32'(doff) + 32'd240);
        o_job.msg_type <= n_msg;
        o_job.yiaddr   <= n_yi;
        o_job.server   <= n_srv;
        o_job.mask     <= n_mask;
        o_job.router   <= n_rtr;
        o_job.dns      <= n_dns;
        o_job.lease    <= n_lease;
    end
endmodule

// ===== rtl/dhcpc_fifo.sv =====
module dhcpc_fifo
    import dhcpc_pkg::*;
#(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    output logic         o_empty,
    input  logic         i_pop,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [4];
    logic [1:0]   r_wp, r_rp;
    logic [2:0]   r_cnt;
    logic         do_push, do_pop;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 2'd1;
            if (do_pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(do_push) - 3'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |=> !(r_cnt == 3'd0)) else $error("queue drained while full");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> r_cnt == $past(r_cnt) + 3'd1)
        else $error("count lost a push");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4) else $error("count overflow");
endmodule

// ===== rtl/dhcpc_proto.sv =====
module dhcpc_proto
    import dhcpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_job        i_job,
    input  logic        i_enabled,
    input  logic [15:0] i_retx_ms,
    input  logic [3:0]  i_max_tries,
    input  logic [31:0] i_fallback,
    output logic        o_valid,
    output logic [1:0]  o_action,
    output logic [1:0]  o_state,
    output logic [31:0] o_our, o_mask, o_router, o_dns, o_lease, o_offer, o_server,
    output logic [3:0]  o_tries
);
    logic [1:0]  r_st, n_st, n_act;
    logic [1:0]  r_act;
    logic [3:0]  r_tries, n_tries;
    logic [31:0] r_last, n_last;
    logic [31:0] r_offer, r_srv, r_our, r_mask, r_rtr, r_dns, r_lease;
    logic [31:0] n_offer, n_srv, n_our, n_mask, n_rtr, n_dns, n_lease;
    logic [4:0]  nxt;
    logic        active;

    always_comb begin
        n_st = r_st; n_tries = r_tries; n_last = r_last; n_act = ACT_NONE;
        n_offer = r_offer; n_srv = r_srv; n_our = r_our; n_mask = r_mask;
        n_rtr = r_rtr; n_dns = r_dns; n_lease = r_lease;
        nxt = 5'(r_tries) + 5'd1;
        active = (r_st == ST_DISCOVER) || (r_st == ST_REQUEST);
        case (i_job.cmd)
            CMD_FRAME: begin
                if (active && i_job.frame_ok) begin
                    if (i_job.msg_type == MSG_OFFER && r_st == ST_DISCOVER) begin
                        n_offer = i_job.yiaddr; n_srv = i_job.server;
                        n_st = ST_REQUEST; n_tries = '0; n_last = i_job.now_ms;
                        n_act = ACT_REQUEST;
                    end else if (i_job.msg_type == MSG_ACK && r_st == ST_REQUEST) begin
                        n_our = i_job.yiaddr; n_mask = i_job.mask;
                        n_rtr = i_job.router; n_dns = i_job.dns;
                        n_lease = i_job.lease; n_st = ST_BOUND; n_act = ACT_ARP;
                    end else if (i_job.msg_type == MSG_NAK) begin
                        n_st = ST_DISCOVER; n_tries = '0;
                        n_last = i_job.now_ms - 32'(i_retx_ms);
                    end
                end
            end
            CMD_TICK: begin
                if (active && (i_job.now_ms - r_last) >= 32'(i_retx_ms)) begin
                    n_last  = i_job.now_ms;
                    n_tries = (nxt > 5'd15) ? 4'd15 : nxt[3:0];
                    if (nxt > 5'(i_max_tries)) begin
                        n_our = i_fallback; n_st = ST_BOUND; n_act = ACT_ARP;
                    end else begin
                        n_act = (r_st == ST_DISCOVER) ? ACT_DISCOVER : ACT_REQUEST;
                    end
                end
            end
            CMD_START: begin
                if (i_enabled) begin
                    n_st = ST_DISCOVER; n_tries = 4'd1; n_last = i_job.now_ms;
                    n_act = ACT_DISCOVER;
                end
            end
            CMD_STOP: n_st = ST_IDLE;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_tries <= '0; r_last <= '0; r_offer <= '0;
            r_srv <= '0; r_our <= '0; r_mask <= DEFAULT_MASK; r_rtr <= '0;
            r_dns <= '0; r_lease <= '0; o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_valid) begin
                r_st <= n_st;
                r_tries <= n_tries; r_last <= n_last; r_offer <= n_offer;
                r_srv <= n_srv; r_our <= n_our; r_mask <= n_mask; r_rtr <= n_rtr;
                r_dns <= n_dns; r_lease <= n_lease; o_valid <= 1'b1;
            end
        end
    end

    assign o_action = r_act;
    always_ff @(posedge i_clk) if (i_valid) r_act <= n_act;
    assign o_state = r_st; assign o_tries = r_tries; assign o_our = r_our;
    assign o_mask = r_mask; assign o_router = r_rtr; assign o_dns = r_dns;
    assign o_lease = r_lease; assign o_offer = r_offer; assign o_server = r_srv;
endmodule

// ===== rtl/dhcp_client_engine.sv =====
// DHCP client engine. Every accepted word yields exactly one result word, in order.
// A word passes the registered frame parser and then the registered protocol stage, then
// enters a four-word result queue whose head drives the result ports. One word per cycle
// is taken back to back while results are popped; full rises once the queued results plus
// the words still in the two stages reach four.
module dhcp_client_engine
    import dhcpc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DhcpcMaxFrameBytes
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_last_byte,
    input  logic [31:0] i_now_ms,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_action,
    output logic [1:0]  o_client_state,
    output logic [31:0] o_bound_ip,
    output logic [31:0] o_subnet_mask,
    output logic [31:0] o_gateway_ip,
    output logic [31:0] o_dns_ip,
    output logic [31:0] o_lease_seconds,
    output logic [31:0] o_offered_ip,
    output logic [31:0] o_server_ip,
    output logic [3:0]  o_try_count,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int RW = 2 + 2 + 32 * 7 + 4;

    logic        r_en;
    logic [31:0] r_xid, r_fb;
    logic [15:0] r_retx;
    logic [3:0]  r_maxt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b0; r_xid <= 32'h5048_4F45; r_retx <= 16'd4000;
            r_maxt <= 4'd5; r_fb <= 32'hC0A8_00C8;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ENABLE:   r_en   <= i_cfg_data[0];
                REG_XID:      r_xid  <= i_cfg_data;
                REG_RETX:     r_retx <= i_cfg_data[15:0];
                REG_MAXTRY:   r_maxt <= i_cfg_data[3:0];
                REG_FALLBACK: r_fb   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Two words may be in flight ahead of the queue, so leave room for them.
    logic       acc, j_valid, p_valid, q_full, q_empty;
    logic [2:0] r_room;
    t_job       job;
    logic [1:0] p_act, p_st;
    logic [3:0] p_tr;
    logic [31:0] p_our, p_mask, p_rtr, p_dns, p_lease, p_off, p_srv;
    logic [RW-1:0] q_in, q_out;
    logic [2:0] inflight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_room <= '0;
        else r_room <= 3'(acc) + 3'(j_valid);
    end
    assign inflight = r_room;

    dhcpc_fifo #(.W(RW)) u_q (
        .i_clk, .i_rst_n, .i_push(p_valid), .i_data(q_in), .o_full(q_full),
        .o_empty(q_empty), .i_pop(pop), .o_data(q_out)
    );

    logic [2:0] q_cnt_est;
    logic [2:0] r_qcnt;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_qcnt <= '0;
        else r_qcnt <= r_qcnt + 3'(p_valid) - 3'(pop && !q_empty);
    end
    assign q_cnt_est = r_qcnt + 3'(j_valid) + 3'(p_valid);
    assign full = (q_cnt_est >= 3'd4) || (inflight == 3'd7) || q_full;
    assign acc  = push && !full;

    dhcpc_parser #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_parse (
        .i_clk, .i_rst_n, .i_valid(acc), .i_mode, .i_rx_byte, .i_last_byte,
        .i_now_ms, .i_xid(r_xid), .o_job_valid(j_valid), .o_job(job)
    );

    dhcpc_proto u_proto (
        .i_clk, .i_rst_n, .i_valid(j_valid), .i_job(job), .i_enabled(r_en),
        .i_retx_ms(r_retx), .i_max_tries(r_maxt), .i_fallback(r_fb),
        .o_valid(p_valid), .o_action(p_act), .o_state(p_st), .o_our(p_our),
        .o_mask(p_mask), .o_router(p_rtr), .o_dns(p_dns), .o_lease(p_lease),
        .o_offer(p_off), .o_server(p_srv), .o_tries(p_tr)
    );

    logic [1:0] p_st_eff;
    assign p_st_eff = p_st;
    assign q_in = {p_act, p_st_eff, p_our, p_mask, p_rtr, p_dns, p_lease, p_off, p_srv, p_tr};

    assign empty = q_empty;
    assign {o_action, o_client_state, o_bound_ip, o_subnet_mask, o_gateway_ip, o_dns_ip,
            o_lease_seconds, o_offered_ip, o_server_ip, o_try_count} = q_out;
endmodule
